// ===== rtl/core/upd_pkg.sv =====
// Shared types and constants for the URL percent decoder.
package upd_pkg;

	// Most decoded bytes one encoded byte can release
	localparam int unsigned UPD_MAX_BYTES = 3;
	localparam int unsigned UPD_CNT_W = $clog2(UPD_MAX_BYTES + 1);

	// Default depth of the queue between front and back
	localparam int unsigned UPD_QUEUE_DEPTH = 4;

	typedef logic [UPD_CNT_W-1:0] upd_cnt_t;

	// One classified request: the bytes it releases, in order
	typedef struct packed {
		upd_cnt_t                         cnt;
		logic [UPD_MAX_BYTES-1:0][7:0]    data;
		logic                             last;
	} upd_cmd_t;

	// Push side of the queue
	typedef struct packed {
		logic     push;
		upd_cmd_t cmd;
	} upd_push_t;

	// Head side of the queue
	typedef struct packed {
		logic     nonempty;
		upd_cmd_t cmd;
	} upd_head_t;

endpackage

// ===== rtl/core/upd_stream_if.sv =====
// Valid/ready channel interfaces for encoded and decoded byte streams.
interface upd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface upd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== rtl/core/upd_front.sv =====
// Front end: accept encoded bytes, track the escape state, build requests.
module upd_front (
	input  logic             clk,
	input  logic             arst_n,
	upd_in_if.sink           rx,
	input  logic             full,
	output upd_pkg::upd_push_t pq
);
	import upd_pkg::*;

	localparam logic [7:0] PCT_CHAR   = 8'h25;
	localparam logic [7:0] PLUS_CHAR  = 8'h2B;
	localparam logic [7:0] SPACE_CHAR = 8'h20;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_PCT   = 3'b010,
		PH_DIGIT = 3'b100
	} phase_t;

	phase_t     phase_q, phase_nxt, phase_byte;
	logic [7:0] held_q, held_nxt;
	logic [7:0] b;
	logic       b_hex, b_pct, accept;
	upd_cmd_t   cmd;

	function automatic logic is_hex(input logic [7:0] c);
		is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		// Letters of either case carry their value minus nine in the low nibble
		hex_value = (c <= 8'h39) ? c[3:0] : c[3:0] + 4'd9;
	endfunction

	// Append one byte to a request
	function automatic upd_cmd_t append(input upd_cmd_t c, input logic [7:0] x);
		upd_cmd_t r;
		r = c;
		case (c.cnt)
			upd_cnt_t'(0): begin
				r.data[0] = x;
				r.cnt = upd_cnt_t'(1);
			end
			upd_cnt_t'(1): begin
				r.data[1] = x;
				r.cnt = upd_cnt_t'(2);
			end
			upd_cnt_t'(2): begin
				r.data[2] = x;
				r.cnt = upd_cnt_t'(3);
			end
			default: r = c;
		endcase
		append = r;
	endfunction

	assign accept   = rx.valid && rx.ready;
	assign rx.ready = !full;

	// Map plus to space before any other decision
	assign b     = (rx.in_byte == PLUS_CHAR) ? SPACE_CHAR : rx.in_byte;
	assign b_hex = is_hex(b);
	assign b_pct = (b == PCT_CHAR);

	// Classify the byte against the held escape prefix
	always_comb begin
		cmd        = '0;
		held_nxt   = held_q;
		phase_byte = PH_IDLE;
		unique case (phase_q)
			PH_PCT: begin
				if (b_hex) begin
					held_nxt   = b;
					phase_byte = PH_DIGIT;
				end else if (b_pct) begin
					cmd        = append(cmd, PCT_CHAR);
					phase_byte = PH_PCT;
				end else begin
					cmd = append(cmd, PCT_CHAR);
					cmd = append(cmd, b);
				end
			end
			PH_DIGIT: begin
				if (b_hex) begin
					cmd = append(cmd, {hex_value(held_q), hex_value(b)});
				end else if (b_pct) begin
					cmd        = append(cmd, PCT_CHAR);
					cmd        = append(cmd, held_q);
					phase_byte = PH_PCT;
				end else begin
					cmd = append(cmd, PCT_CHAR);
					cmd = append(cmd, held_q);
					cmd = append(cmd, b);
				end
			end
			default: begin
				if (b_pct) begin
					phase_byte = PH_PCT;
				end else begin
					cmd = append(cmd, b);
				end
			end
		endcase

		// Flush whatever is still held on the final byte
		phase_nxt = phase_byte;
		if (rx.in_last) begin
			if (phase_byte == PH_PCT) begin
				cmd = append(cmd, PCT_CHAR);
			end else if (phase_byte == PH_DIGIT) begin
				cmd = append(cmd, PCT_CHAR);
				cmd = append(cmd, held_nxt);
			end
			phase_nxt = PH_IDLE;
			cmd.last  = 1'b1;
		end
	end

	assign pq.push = accept && (cmd.cnt != upd_cnt_t'(0));
	assign pq.cmd  = cmd;

	// Advance escape state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			held_q  <= held_nxt;
		end
	end

endmodule

// ===== rtl/core/upd_queue.sv =====
// Small register queue of classified requests between front and back.
module upd_queue #(
	parameter int unsigned DEPTH = upd_pkg::UPD_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  upd_pkg::upd_push_t pq,
	input  logic               pop,
	output logic               full,
	output upd_pkg::upd_head_t hd
);
	import upd_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	upd_cmd_t        slot_q [DEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push, do_pop;

	assign full        = (cnt_q == CW'(DEPTH));
	assign hd.nonempty = (cnt_q != '0);
	assign hd.cmd      = slot_q[rd_q];
	assign do_push     = pq.push && !full;
	assign do_pop      = pop && hd.nonempty;

	// Store request at the write pointer
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= pq.cmd;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/upd_back.sv =====
// Back end: emit the bytes of the head request one per cycle while the output is ready.
module upd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  upd_pkg::upd_head_t hd,
	output logic               pop,
	upd_out_if.source          tx
);
	import upd_pkg::*;

	upd_cnt_t idx_q;
	logic     at_end, take;

	assign tx.valid = hd.nonempty;
	assign take     = tx.valid && tx.ready;
	assign at_end   = (idx_q == hd.cmd.cnt - upd_cnt_t'(1));
	assign pop      = take && at_end;
	assign tx.out_last = hd.cmd.last && at_end;

	// Select the current byte of the head request
	always_comb begin
		case (idx_q)
			upd_cnt_t'(1): tx.out_byte = hd.cmd.data[1];
			upd_cnt_t'(2): tx.out_byte = hd.cmd.data[2];
			default:       tx.out_byte = hd.cmd.data[0];
		endcase
	end

	// Advance within the request, rewind when it retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (pop) begin
			idx_q <= '0;
		end else if (take) begin
			idx_q <= idx_q + upd_cnt_t'(1);
		end
	end

endmodule

// ===== rtl/core/url_percent_decoder_unit.sv =====
// Path: the front end builds a request from each encoded byte combinationally; the queue
// registers it before the back end offers its bytes. Throughput: one encoded byte per cycle
// while the request queue has room; the back end sends one decoded byte per cycle while the
// output is ready, so input keeps flowing behind a broken escape only while the queue has room.
// Reset: arst_n clears the escape state and empties the queue; no memory clearing pass.
module url_percent_decoder_unit #(
	parameter int unsigned QUEUE_DEPTH = upd_pkg::UPD_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	upd_in_if.sink    rx,
	upd_out_if.source tx
);
	import upd_pkg::*;

	upd_push_t pq;
	upd_head_t hd;
	logic      full, pop;

	// Classify incoming bytes
	upd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.full   (full),
		.pq     (pq)
	);

	// Decouple front and back
	upd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.pq     (pq),
		.pop    (pop),
		.full   (full),
		.hd     (hd)
	);

	// Emit decoded bytes
	upd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.hd     (hd),
		.pop    (pop),
		.tx     (tx)
	);

endmodule

// ===== rtl/core/upd_checker.sv =====
// Port-level checks for the URL percent decoder, bound to the top level.
module upd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rx_valid,
	input logic       rx_ready,
	input logic       rx_in_last,
	input logic       tx_valid,
	input logic       tx_ready,
	input logic [7:0] tx_out_byte,
	input logic       tx_out_last
);

	// Hold an offered decoded byte until it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_ready |=> tx_valid)
		else $error("decoded byte withdrawn before it was taken");

	// Keep the stalled payload steady
	assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_ready |=> $stable(tx_out_byte) && $stable(tx_out_last))
		else $error("decoded byte changed while stalled");

	// A full queue always has something to send
	assert property (@(posedge clk) disable iff (!arst_n)
		!rx_ready |-> tx_valid)
		else $error("input stalled with nothing to send");

	// A final byte always releases output
	assert property (@(posedge clk) disable iff (!arst_n)
		rx_valid && rx_ready && rx_in_last && !tx_valid |=> tx_valid)
		else $error("final byte released no output");

endmodule

bind url_percent_decoder_unit upd_checker u_upd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rx_valid    (rx.valid),
	.rx_ready    (rx.ready),
	.rx_in_last  (rx.in_last),
	.tx_valid    (tx.valid),
	.tx_ready    (tx.ready),
	.tx_out_byte (tx.out_byte),
	.tx_out_last (tx.out_last)
);

// ===== tb/url_percent_decoder_unit_tb.sv =====
// Testbench for the URL percent decoder: directed and random byte streams, scoreboard check.
`timescale 1ns / 1ps

module url_percent_decoder_unit_tb;

	localparam logic [7:0] PCT_CHAR   = 8'h25;
	localparam logic [7:0] PLUS_CHAR  = 8'h2B;
	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam int RANDOM_ITEMS = 220;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_OFF     = 120;

	typedef enum logic [1:0] {
		ESC_NONE,
		ESC_PCT,
		ESC_DIGIT
	} esc_phase_t;

	typedef struct {
		logic [7:0] data;
		logic       last_flag;
	} decoded_byte_t;

	// Predicts decoded bytes from accepted requests and checks the output stream
	class decode_scoreboard;
		esc_phase_t    phase;
		logic [7:0]    held_digit;
		decoded_byte_t pending_q[$];
		int            errors;

		function new();
			phase = ESC_NONE;
			held_digit = 8'h00;
			errors = 0;
		endfunction

		function bit is_hex(input logic [7:0] c);
			return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") ||
				(c >= "a" && c <= "f");
		endfunction

		function logic [3:0] nibble_of(input logic [7:0] c);
			logic [7:0] v;
			if (c <= "9")
				v = c - "0";
			else
				v = (c | 8'h20) - "a" + 8'd10;
			return v[3:0];
		endfunction

		function void report(input string what, input logic [7:0] exp_b, input logic exp_l,
				input logic [7:0] got_b, input logic got_l);
			if (errors < 40)
				$display("mismatch at %0t: %s: expected %02h/%0b, got %02h/%0b",
					$realtime, what, exp_b, exp_l, got_b, got_l);
			errors++;
		endfunction

		// Decode one encoded byte and queue the bytes it releases
		function void note_request(input logic [7:0] raw, input logic fin);
			logic [7:0] c;
			logic [7:0] released[$];
			decoded_byte_t d;
			c = (raw == PLUS_CHAR) ? SPACE_CHAR : raw;
			case (phase)
				ESC_PCT: begin
					if (is_hex(c)) begin
						held_digit = c;
						phase = ESC_DIGIT;
					end else if (c == PCT_CHAR) begin
						released.push_back(PCT_CHAR);
					end else begin
						released.push_back(PCT_CHAR);
						released.push_back(c);
						phase = ESC_NONE;
					end
				end
				ESC_DIGIT: begin
					if (is_hex(c)) begin
						released.push_back({nibble_of(held_digit), nibble_of(c)});
						phase = ESC_NONE;
					end else if (c == PCT_CHAR) begin
						released.push_back(PCT_CHAR);
						released.push_back(held_digit);
						phase = ESC_PCT;
					end else begin
						released.push_back(PCT_CHAR);
						released.push_back(held_digit);
						released.push_back(c);
						phase = ESC_NONE;
					end
				end
				default: begin
					if (c == PCT_CHAR)
						phase = ESC_PCT;
					else
						released.push_back(c);
				end
			endcase
			// flush whatever is held at the end of a string
			if (fin) begin
				if (phase == ESC_PCT) begin
					released.push_back(PCT_CHAR);
				end else if (phase == ESC_DIGIT) begin
					released.push_back(PCT_CHAR);
					released.push_back(held_digit);
				end
				phase = ESC_NONE;
			end
			foreach (released[i]) begin
				d.data = released[i];
				d.last_flag = fin && (i == released.size() - 1);
				pending_q.push_back(d);
			end
		endfunction

		// Compare one decoded byte with the oldest expectation
		function void check_result(input logic [7:0] got_b, input logic got_l);
			decoded_byte_t d;
			if (pending_q.size() == 0) begin
				report("unexpected byte", 8'h00, 1'b0, got_b, got_l);
				return;
			end
			d = pending_q.pop_front();
			if (got_b !== d.data)
				report("out_byte", d.data, d.last_flag, got_b, got_l);
			if (got_l !== d.last_flag)
				report("out_last", d.data, d.last_flag, got_b, got_l);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   decoded_seen;
	int   idle_cycles;
	int   burst_left;
	bit   long_hold_done;
	decode_scoreboard sb = new();

	upd_in_if  rx_if();
	upd_out_if tx_if();

	url_percent_decoder_unit dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_if),
		.tx    (tx_if)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Pick a gap before the next request: mostly none or short, some long, some bursts
	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			burst_left = $urandom_range(10, 40);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] random_hex_char();
		int v;
		v = $urandom_range(0, 21);
		if (v < 10)
			return 8'h30 + 8'(v);
		if (v < 16)
			return 8'h41 + 8'(v - 10);
		return 8'h61 + 8'(v - 16);
	endfunction

	function automatic logic [7:0] random_non_hex();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (sb.is_hex(b) || b == PCT_CHAR || b == PLUS_CHAR);
		return b;
	endfunction

	// Offer one request and hold it until accepted
	task automatic send_request(input logic [7:0] b, input logic fin);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.in_byte <= b;
		rx_if.in_last <= fin;
		do
			@(posedge clk);
		while (!rx_if.ready);
	endtask

	task automatic send_text(input string s, input bit fin);
		for (int i = 0; i < s.len(); i++)
			send_request(s[i], fin && (i == s.len() - 1));
	endtask

	// Send one random sequence: well-formed escapes most often, the rest plain bytes, plus signs, noise and broken ones
	task automatic send_random_sequence(output int count);
		logic [7:0] seq[$];
		int k;
		k = $urandom_range(0, 99);
		if (k < 45) begin
			seq.push_back(PCT_CHAR);
			seq.push_back(random_hex_char());
			seq.push_back(random_hex_char());
		end else if (k < 60) begin
			seq.push_back(random_non_hex());
		end else if (k < 68) begin
			seq.push_back(PLUS_CHAR);
		end else if (k < 83) begin
			seq.push_back(PCT_CHAR);
			if ($urandom_range(0, 1))
				seq.push_back(random_hex_char());
			case ($urandom_range(0, 3))
				0: seq.push_back(PCT_CHAR);
				1: seq.push_back(PLUS_CHAR);
				default: seq.push_back(random_non_hex());
			endcase
		end else begin
			seq.push_back(8'($urandom_range(0, 255)));
		end
		foreach (seq[i])
			send_request(seq[i], $urandom_range(0, 9) == 0);
		count = seq.size();
	endtask

	// Reset, directed strings, random stream, then drain and report
	initial begin : stimulus
		int sent;
		int n;
		arst_n        <= 1'b0;
		rx_if.valid   <= 1'b0;
		rx_if.in_byte <= 8'h00;
		rx_if.in_last <= 1'b0;
		tx_if.ready   <= 1'b0;
		burst_left = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(8'h00, 1'b0);
		send_request(8'hFF, 1'b1);
		send_text("+", 1'b1);
		send_text("%4a", 1'b0);
		send_text("%fF", 1'b1);
		send_text("%+", 1'b0);
		send_text("%%0", 1'b1);
		send_text("%9%", 1'b1);
		send_text("%Az", 1'b0);
		send_text("%", 1'b1);
		send_text("%g", 1'b1);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			send_random_sequence(n);
			sent += n;
		end
		rx_if.valid <= 1'b0;

		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Drive output ready: random stalls, plus one long hold-off to back up the queue
	initial begin : receiver
		int r;
		int len;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!long_hold_done && decoded_seen >= 40) begin
				long_hold_done = 1'b1;
				tx_if.ready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					tx_if.ready <= 1'b1;
					len = $urandom_range(1, 24);
				end else if (r < 88) begin
					tx_if.ready <= 1'b0;
					len = $urandom_range(1, 3);
				end else begin
					tx_if.ready <= 1'b0;
					len = $urandom_range(8, 30);
				end
				repeat (len) @(posedge clk);
			end
		end
	end

	// Observe both channels and watch for a stuck run
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_if.valid && rx_if.ready)
				sb.note_request(rx_if.in_byte, rx_if.in_last);
			if (tx_if.valid && tx_if.ready) begin
				sb.check_result(tx_if.out_byte, tx_if.out_last);
				decoded_seen++;
			end
			if ((rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

endmodule
